@@ hdl/bpc_pkg.sv @@
// Shared types and constants for the barometric compensation pipeline.
`default_nettype none

package bpc_pkg;

    localparam int CAL_W   = 16;
    localparam int RAW_W   = 24;
    localparam int TEMP_W  = 16;
    localparam int PRES_W  = 18;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int NUM_STG = 9;

    // compensated offset and sensitivity, and the pressure product after the first shift
    localparam int SENS_W = 41;
    localparam int X_W    = 45;

    localparam logic [2:0] REG_C1 = 3'd0;
    localparam logic [2:0] REG_C2 = 3'd1;
    localparam logic [2:0] REG_C3 = 3'd2;
    localparam logic [2:0] REG_C4 = 3'd3;
    localparam logic [2:0] REG_C5 = 3'd4;
    localparam logic [2:0] REG_C6 = 3'd5;

    localparam logic signed [18:0] TEMP_REF  = 19'sd2000;
    localparam logic signed [18:0] TEMP_COLD = 19'sd1500;

    localparam logic signed [19:0]       TEMP_LO = -20'sd32768;
    localparam logic signed [19:0]       TEMP_HI = 20'sd32767;
    localparam logic signed [30:0]       PRES_HI = 31'sd262143;
    localparam logic [PRES_W-1:0]        PRES_MAX = 18'h3FFFF;

    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } t_mul_ctl;

endpackage

`default_nettype wire

@@ hdl/bpc_pmul.sv @@
// Two-stage split multiplier: raw pressure times compensated sensitivity, shifted by 21.
`default_nettype none

module bpc_pmul
    import bpc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_mul_ctl                 i_ctl,
    input  wire logic [RAW_W-1:0]         i_d1,
    input  wire logic signed [SENS_W-1:0] i_sens,
    output logic signed [X_W-1:0]         o_x
);

    logic [43:0]        r_lo;
    logic signed [45:0] r_hi;
    logic signed [X_W-1:0] r_x;

    logic [43:0]        n_lo;
    logic signed [45:0] n_hi;
    logic signed [65:0] n_prod;

    always_comb begin
        n_lo   = i_d1 * i_sens[19:0];
        n_hi   = $signed({1'b0, i_d1}) * $signed(i_sens[SENS_W-1:20]);
        n_prod = $signed({r_hi, 20'h00000}) + $signed({22'b0, r_lo});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_ctl.en_sum) begin
            r_x <= n_prod[65:21];
        end
    end

    assign o_x = r_x;

endmodule

`default_nettype wire

@@ hdl/baro_pressure_temp_compensation.sv @@
// Top level: pipelined second-order barometric pressure and temperature compensation.
`default_nettype none

// Each transfer of a raw pressure and raw temperature pair yields one transfer of
// compensated temperature (0.01 C, saturated to 16 bits signed) and pressure (Pa,
// saturated to 0..262143). The datapath is a nine-stage pipeline with a stall enable
// per stage: one pair is accepted every cycle unless a full pipeline waits on the
// output; a bubble anywhere lets input keep flowing while the output waits. The six
// calibration words sit at byte addresses 0x00..0x14 of the APB port, low 16 bits,
// and must only be written while the pipeline is empty.
module baro_pressure_temp_compensation
    import bpc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,

    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [RAW_W-1:0]    i_raw_pressure,
    input  wire logic [RAW_W-1:0]    i_raw_temperature,

    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [TEMP_W-1:0] o_temperature_centi,
    output logic [PRES_W-1:0]        o_pressure_pa
);

    // calibration registers
    logic [CAL_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic             cfg_wr;
    logic [2:0]       cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_C1:  r_c1 <= pwdata[CAL_W-1:0];
                REG_C2:  r_c2 <= pwdata[CAL_W-1:0];
                REG_C3:  r_c3 <= pwdata[CAL_W-1:0];
                REG_C4:  r_c4 <= pwdata[CAL_W-1:0];
                REG_C5:  r_c5 <= pwdata[CAL_W-1:0];
                REG_C6:  r_c6 <= pwdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_C1:  prdata = {16'h0000, r_c1};
            REG_C2:  prdata = {16'h0000, r_c2};
            REG_C3:  prdata = {16'h0000, r_c3};
            REG_C4:  prdata = {16'h0000, r_c4};
            REG_C5:  prdata = {16'h0000, r_c5};
            REG_C6:  prdata = {16'h0000, r_c6};
            default: prdata = '0;
        endcase
    end

    // stage valids and enables
    logic [NUM_STG:1] r_vld;
    logic [NUM_STG:1] en;

    always_comb begin
        en[NUM_STG] = !r_vld[NUM_STG] || i_out_ready;
        for (int k = NUM_STG - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NUM_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = en[1];
    assign o_out_valid = r_vld[NUM_STG];

    // stage 1: dT
    logic signed [24:0] r1_dt, n1_dt;
    logic [RAW_W-1:0]   r1_d1;

    assign n1_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, r_c5, 8'h00});

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_dt <= n1_dt;
            r1_d1 <= i_raw_pressure;
        end
    end

    // stage 2: first-order products
    logic signed [41:0] r2_pt, r2_poff, r2_psens, n2_pt, n2_poff, n2_psens;
    logic signed [49:0] r2_pdd, n2_pdd;
    logic [RAW_W-1:0]   r2_d1;

    always_comb begin
        n2_pt    = r1_dt * $signed({1'b0, r_c6});
        n2_poff  = r1_dt * $signed({1'b0, r_c4});
        n2_psens = r1_dt * $signed({1'b0, r_c3});
        n2_pdd   = r1_dt * r1_dt;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_pt    <= n2_pt;
            r2_poff  <= n2_poff;
            r2_psens <= n2_psens;
            r2_pdd   <= n2_pdd;
            r2_d1    <= r1_d1;
        end
    end

    // stage 3: TEMP, OFF, SENS, T2
    logic signed [18:0]       r3_temp, n3_temp;
    logic signed [SENS_W-1:0] r3_off, r3_sens, n3_off, n3_sens;
    logic [17:0]              r3_t2;
    logic [RAW_W-1:0]         r3_d1;

    always_comb begin
        n3_temp = $signed(r2_pt[41:23]) + TEMP_REF;
        n3_off  = $signed({9'b0, r_c2, 16'h0000})
                + $signed({{6{r2_poff[41]}}, r2_poff[41:7]});
        n3_sens = $signed({10'b0, r_c1, 15'h0000})
                + $signed({{7{r2_psens[41]}}, r2_psens[41:8]});
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_temp <= n3_temp;
            r3_off  <= n3_off;
            r3_sens <= n3_sens;
            r3_t2   <= r2_pdd[48:31];
            r3_d1   <= r2_d1;
        end
    end

    // stage 4: squares of the distances below 20 C and -15 C
    logic signed [18:0]       n4_a, n4_b;
    logic signed [37:0]       n4_sqa, n4_sqb;
    logic [34:0]              r4_sq, r4_sq2;
    logic                     r4_lt2k, r4_lt15;
    logic signed [18:0]       r4_temp;
    logic [17:0]              r4_t2;
    logic signed [SENS_W-1:0] r4_off, r4_sens;
    logic [RAW_W-1:0]         r4_d1;

    always_comb begin
        n4_a   = r3_temp - TEMP_REF;
        n4_b   = r3_temp + TEMP_COLD;
        n4_sqa = n4_a * n4_a;
        n4_sqb = n4_b * n4_b;
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_sq   <= n4_sqa[34:0];
            r4_sq2  <= n4_sqb[34:0];
            r4_lt2k <= n4_a[18];
            r4_lt15 <= n4_b[18];
            r4_temp <= r3_temp;
            r4_t2   <= r3_t2;
            r4_off  <= r3_off;
            r4_sens <= r3_sens;
            r4_d1   <= r3_d1;
        end
    end

    // stage 5: second-order terms, final temperature
    logic [36:0]              n5_sq5;
    logic [37:0]              n5_sq7, n5_sq11;
    logic [39:0]              r5_off2, r5_sens2, n5_off2, n5_sens2;
    logic signed [19:0]       n5_tf;
    logic signed [TEMP_W-1:0] r5_temp, n5_temp;
    logic signed [SENS_W-1:0] r5_off, r5_sens;
    logic [RAW_W-1:0]         r5_d1;

    always_comb begin
        n5_sq5  = {r4_sq, 2'b00} + {2'b00, r4_sq};
        n5_sq7  = {r4_sq2, 3'b000} - {3'b000, r4_sq2};
        n5_sq11 = {r4_sq2, 3'b000} + {2'b00, r4_sq2, 1'b0} + {3'b000, r4_sq2};
        n5_off2  = '0;
        n5_sens2 = '0;
        if (r4_lt2k) begin
            n5_off2  = {4'b0, n5_sq5[36:1]};
            n5_sens2 = {5'b0, n5_sq5[36:2]};
            if (r4_lt15) begin
                n5_off2  = n5_off2 + {2'b00, n5_sq7};
                n5_sens2 = n5_sens2 + {3'b000, n5_sq11[37:1]};
            end
        end
        n5_tf = $signed({r4_temp[18], r4_temp})
              - $signed(r4_lt2k ? {2'b00, r4_t2} : 20'h00000);
        priority if (n5_tf < TEMP_LO) begin
            n5_temp = TEMP_LO[TEMP_W-1:0];
        end else if (n5_tf > TEMP_HI) begin
            n5_temp = TEMP_HI[TEMP_W-1:0];
        end else begin
            n5_temp = n5_tf[TEMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_off2  <= n5_off2;
            r5_sens2 <= n5_sens2;
            r5_temp  <= n5_temp;
            r5_off   <= r4_off;
            r5_sens  <= r4_sens;
            r5_d1    <= r4_d1;
        end
    end

    // stage 6: corrected OFF and SENS
    logic signed [SENS_W-1:0] r6_off, r6_sens;
    logic signed [TEMP_W-1:0] r6_temp;
    logic [RAW_W-1:0]         r6_d1;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_off  <= r5_off - $signed({1'b0, r5_off2});
            r6_sens <= r5_sens - $signed({1'b0, r5_sens2});
            r6_temp <= r5_temp;
            r6_d1   <= r5_d1;
        end
    end

    // stages 7 and 8: D1 * SENS >> 21
    t_mul_ctl                 mul_ctl;
    logic signed [X_W-1:0]    mul_x;
    logic signed [SENS_W-1:0] r7_off, r8_off;
    logic signed [TEMP_W-1:0] r7_temp, r8_temp;

    assign mul_ctl.en_mul = en[7];
    assign mul_ctl.en_sum = en[8];

    bpc_pmul u_pmul (
        .i_clk  (i_clk),
        .i_ctl  (mul_ctl),
        .i_d1   (r6_d1),
        .i_sens (r6_sens),
        .o_x    (mul_x)
    );

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_off  <= r6_off;
            r7_temp <= r6_temp;
        end
        if (en[8]) begin
            r8_off  <= r7_off;
            r8_temp <= r7_temp;
        end
    end

    // stage 9: P and saturation
    logic signed [45:0]       n9_y;
    logic signed [30:0]       n9_p;
    logic [PRES_W-1:0]        r9_pres, n9_pres;
    logic signed [TEMP_W-1:0] r9_temp;

    always_comb begin
        n9_y = $signed({mul_x[X_W-1], mul_x}) - $signed({{5{r8_off[SENS_W-1]}}, r8_off});
        n9_p = n9_y[45:15];
        priority if (n9_p[30]) begin
            n9_pres = '0;
        end else if (n9_p > PRES_HI) begin
            n9_pres = PRES_MAX;
        end else begin
            n9_pres = n9_p[PRES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r9_pres <= n9_pres;
            r9_temp <= r8_temp;
        end
    end

    assign o_temperature_centi = r9_temp;
    assign o_pressure_pa       = r9_pres;

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while pipeline full and stalled");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[1])
        else $error("accepted transfer lost at first stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
